FILE: design/psd_pkg.sv
// Shared types and constants for the parallel subplan dispatcher.
package psd_pkg;

    // Plan indices on the ports are six bits wide; the scan index needs one more
    // bit so that it can hold the plan count itself.
    localparam int PLAN_W = 6;
    localparam int IDX_W  = 7;
    localparam int MASK_W = 64;
    localparam int CFG_AW = 2;

    typedef enum logic [1:0] {
        OP_LEADER  = 2'd0,
        OP_WORKER  = 2'd1,
        OP_RESTART = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef enum logic [CFG_AW-1:0] {
        CFG_NUM_PLANS     = 2'd0,
        CFG_FIRST_PARTIAL = 2'd1,
        CFG_VALID_MASK    = 2'd2,
        CFG_NONE          = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEADER,
        S_WFIRST,
        S_WSCAN,
        S_WWRAP,
        S_NSCAN,
        S_NWRAP,
        S_RESP
    } t_state;

    // Update request toward the mark store.
    typedef struct packed {
        logic             clr;
        logic             set;
        logic [IDX_W-1:0] idx;
    } t_mark_cmd;

    // Answer of the mark store for the probed index.
    typedef struct packed {
        logic valid;
        logic done;
    } t_probe;

endpackage

FILE: design/parallel_subplan_dispatcher_top.sv
// Top level of the parallel subplan dispatcher: configuration registers and wiring.
// Requests are accepted one at a time, only while the sequencer is idle; the scan
// probes one plan index per cycle, and the result beat is held until the consumer takes it.
// Reset (synchronous, active low): all finished marks, the next pointer and the
// exhausted flag clear; the registers return to one plan, first partial 0, mask 1.
module parallel_subplan_dispatcher_top #(
    parameter int MAX_PLANS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel.
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_op,
    input  logic                            i_has_current,
    input  logic [5:0]                      i_current_plan,
    // Result channel.
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_granted,
    output logic [5:0]                      o_plan,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [psd_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [psd_pkg::MASK_W-1:0]      i_cfg_wdata
);

    // Only as many plans as the port width can name are ever stored.
    localparam int SLOTS = (MAX_PLANS < 64) ? MAX_PLANS : 64;

    logic [psd_pkg::IDX_W-1:0]  r_num_plans;
    logic [psd_pkg::IDX_W-1:0]  r_first_partial;
    logic [psd_pkg::MASK_W-1:0] r_valid_mask;

    logic [psd_pkg::IDX_W-1:0]  plan_n;
    logic [psd_pkg::IDX_W-1:0]  probe_idx;
    psd_pkg::t_probe            probe;
    psd_pkg::t_mark_cmd         mark_cmd;

    // Registers are to be written only between requests, so they feed the
    // sequencer directly; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_plans     <= psd_pkg::IDX_W'(1);
            r_first_partial <= '0;
            r_valid_mask    <= psd_pkg::MASK_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (psd_pkg::t_cfg_reg'(i_cfg_addr))
                psd_pkg::CFG_NUM_PLANS:     r_num_plans     <= i_cfg_wdata[psd_pkg::IDX_W-1:0];
                psd_pkg::CFG_FIRST_PARTIAL: r_first_partial <= i_cfg_wdata[psd_pkg::IDX_W-1:0];
                psd_pkg::CFG_VALID_MASK:    r_valid_mask    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The plan count in use is capped at the number of stored marks; plans
    // at or above it count as finished and are never valid.
    assign plan_n = (r_num_plans > psd_pkg::IDX_W'(SLOTS)) ? psd_pkg::IDX_W'(SLOTS)
                                                            : r_num_plans;

    // The sequencer walks one index per cycle and asks the mark store about
    // it; marks are set or cleared on its command.
    psd_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .o_in_ready      (o_ready),
        .i_op            (i_op),
        .i_has_current   (i_has_current),
        .i_current_plan  (i_current_plan),
        .i_n             (plan_n),
        .i_first_partial (r_first_partial),
        .i_probe         (probe),
        .o_probe_idx     (probe_idx),
        .o_cmd           (mark_cmd),
        .o_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .o_granted       (o_granted),
        .o_plan          (o_plan)
    );

    psd_marks #(
        .SLOTS (SLOTS)
    ) u_marks (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (mark_cmd),
        .i_probe_idx  (probe_idx),
        .i_n          (plan_n),
        .i_valid_mask (r_valid_mask),
        .o_probe      (probe)
    );

endmodule

FILE: design/psd_marks.sv
// Finished-mark store with a single probe port that answers valid and done.
module psd_marks #(
    parameter int SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psd_pkg::t_mark_cmd              i_cmd,
    input  logic [psd_pkg::IDX_W-1:0]       i_probe_idx,
    input  logic [psd_pkg::IDX_W-1:0]       i_n,
    input  logic [psd_pkg::MASK_W-1:0]      i_valid_mask,
    output psd_pkg::t_probe                 o_probe
);

    localparam int MAW = $clog2(SLOTS);

    logic [SLOTS-1:0] r_marks;
    logic             in_range;
    logic             mark_bit;
    logic             mask_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (i_cmd.clr) begin
            r_marks <= '0;
        end else if (i_cmd.set && (i_cmd.idx < psd_pkg::IDX_W'(SLOTS))) begin
            r_marks[i_cmd.idx[MAW-1:0]] <= 1'b1;
        end
    end

    always_comb begin
        in_range = (i_probe_idx < i_n) && (i_probe_idx < psd_pkg::IDX_W'(SLOTS));
        mark_bit = in_range ? r_marks[i_probe_idx[MAW-1:0]] : 1'b0;
        mask_bit = i_valid_mask[i_probe_idx[psd_pkg::PLAN_W-1:0]];
        o_probe.valid = in_range && mask_bit;
        o_probe.done  = !in_range || mark_bit || !mask_bit;
    end

endmodule

FILE: design/psd_seq.sv
// Request sequencer: steps one scan index per cycle through the shared probe.
module psd_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic                            i_has_current,
    input  logic [psd_pkg::PLAN_W-1:0]      i_current_plan,
    input  logic [psd_pkg::IDX_W-1:0]       i_n,
    input  logic [psd_pkg::IDX_W-1:0]       i_first_partial,
    input  psd_pkg::t_probe                 i_probe,
    output logic [psd_pkg::IDX_W-1:0]       o_probe_idx,
    output psd_pkg::t_mark_cmd              o_cmd,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_granted,
    output logic [psd_pkg::PLAN_W-1:0]      o_plan
);

    psd_pkg::t_state                r_state, n_state;
    logic [psd_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [psd_pkg::IDX_W-1:0]      r_start, n_start;
    logic [psd_pkg::PLAN_W-1:0]     r_p, n_p;
    logic [psd_pkg::PLAN_W-1:0]     r_ptr, n_ptr;
    logic                           r_none, n_none;
    logic                           r_gnt, n_gnt;
    logic [psd_pkg::PLAN_W-1:0]     r_plan, n_plan;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_gnt, n_out_gnt;
    logic [psd_pkg::PLAN_W-1:0]     r_out_plan, n_out_plan;

    logic                           at_end;
    logic                           cur_in;
    logic                           slot_free;
    logic [psd_pkg::IDX_W-1:0]      idx_inc;
    logic [psd_pkg::IDX_W-1:0]      cur_ext;
    logic [psd_pkg::IDX_W-1:0]      p_ext;
    psd_pkg::t_op                   op;

    assign op        = psd_pkg::t_op'(i_op);
    assign at_end    = r_idx >= i_n;
    assign idx_inc   = psd_pkg::IDX_W'(r_idx + psd_pkg::IDX_W'(1));
    assign cur_ext   = {1'b0, i_current_plan};
    assign p_ext     = {1'b0, r_p};
    assign cur_in    = i_has_current && (cur_ext < i_n);
    assign slot_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (op == psd_pkg::OP_LEADER && i_n != '0) begin
                        n_state = psd_pkg::S_LEADER;
                    end else if (op == psd_pkg::OP_WORKER && i_n != '0 && !r_none) begin
                        n_state = psd_pkg::S_WFIRST;
                    end else begin
                        n_state = psd_pkg::S_RESP;
                    end
                end
            end
            psd_pkg::S_LEADER: begin
                if (!i_probe.done || r_idx == '0) n_state = psd_pkg::S_RESP;
            end
            psd_pkg::S_WFIRST: begin
                n_state = i_probe.done ? psd_pkg::S_WSCAN : psd_pkg::S_NSCAN;
            end
            psd_pkg::S_WSCAN: begin
                if (at_end) begin
                    n_state = (r_start > i_first_partial) ? psd_pkg::S_WWRAP
                                                          : psd_pkg::S_RESP;
                end else if (i_probe.valid && !i_probe.done) begin
                    n_state = psd_pkg::S_NSCAN;
                end
            end
            psd_pkg::S_WWRAP: begin
                if (at_end || (i_probe.valid && r_idx == r_start)) begin
                    n_state = psd_pkg::S_RESP;
                end else if (i_probe.valid && !i_probe.done) begin
                    n_state = psd_pkg::S_NSCAN;
                end
            end
            psd_pkg::S_NSCAN: begin
                if (at_end) begin
                    n_state = psd_pkg::S_NWRAP;
                end else if (i_probe.valid) begin
                    n_state = psd_pkg::S_RESP;
                end
            end
            psd_pkg::S_NWRAP: begin
                if (at_end || i_probe.valid) n_state = psd_pkg::S_RESP;
            end
            psd_pkg::S_RESP: begin
                if (slot_free) n_state = psd_pkg::S_IDLE;
            end
            default: n_state = psd_pkg::S_IDLE;
        endcase
    end

    // Datapath updates and mark commands.
    always_comb begin
        n_idx       = r_idx;
        n_start     = r_start;
        n_p         = r_p;
        n_ptr       = r_ptr;
        n_none      = r_none;
        n_gnt       = r_gnt;
        n_plan      = r_plan;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_gnt   = r_out_gnt;
        n_out_plan  = r_out_plan;
        o_cmd       = '0;
        unique case (r_state)
            psd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_gnt  = 1'b0;
                    n_plan = '0;
                    unique case (op)
                        psd_pkg::OP_RESTART: begin
                            o_cmd.clr = 1'b1;
                            n_ptr     = '0;
                            n_none    = 1'b0;
                        end
                        psd_pkg::OP_LEADER: begin
                            if (i_n != '0) begin
                                o_cmd.set = cur_in;
                                o_cmd.idx = cur_ext;
                                n_idx     = cur_in ? cur_ext
                                                   : psd_pkg::IDX_W'(i_n - psd_pkg::IDX_W'(1));
                            end
                        end
                        psd_pkg::OP_WORKER: begin
                            if (i_n != '0) begin
                                o_cmd.set = cur_in;
                                o_cmd.idx = cur_ext;
                                n_idx     = {1'b0, r_ptr};
                                n_start   = {1'b0, r_ptr};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            psd_pkg::S_LEADER: begin
                if (!i_probe.done) begin
                    n_gnt     = 1'b1;
                    n_plan    = r_idx[psd_pkg::PLAN_W-1:0];
                    o_cmd.set = r_idx < i_first_partial;
                    o_cmd.idx = r_idx;
                end else if (r_idx == '0) begin
                    n_none = 1'b1;
                end else begin
                    n_idx = psd_pkg::IDX_W'(r_idx - psd_pkg::IDX_W'(1));
                end
            end
            psd_pkg::S_WFIRST: begin
                if (!i_probe.done) n_p = r_idx[psd_pkg::PLAN_W-1:0];
                n_idx = idx_inc;
            end
            psd_pkg::S_WSCAN: begin
                if (at_end) begin
                    if (r_start > i_first_partial) begin
                        n_idx = i_first_partial;
                    end else begin
                        n_none = 1'b1;
                        n_ptr  = '0;
                    end
                end else begin
                    if (i_probe.valid && !i_probe.done) n_p = r_idx[psd_pkg::PLAN_W-1:0];
                    n_idx = idx_inc;
                end
            end
            psd_pkg::S_WWRAP: begin
                if (at_end || (i_probe.valid && r_idx == r_start)) begin
                    n_none = 1'b1;
                    n_ptr  = '0;
                end else begin
                    if (i_probe.valid && !i_probe.done) n_p = r_idx[psd_pkg::PLAN_W-1:0];
                    n_idx = idx_inc;
                end
            end
            psd_pkg::S_NSCAN, psd_pkg::S_NWRAP: begin
                if (at_end && r_state == psd_pkg::S_NSCAN) begin
                    n_idx = i_first_partial;
                end else if (at_end || i_probe.valid) begin
                    // The grant is final here: set the successor pointer, or flag exhaustion
                    // at the end of the wrap, and retire a non-partial plan.
                    if (at_end) begin
                        n_none = 1'b1;
                        n_ptr  = '0;
                    end else begin
                        n_ptr = r_idx[psd_pkg::PLAN_W-1:0];
                    end
                    n_gnt     = 1'b1;
                    n_plan    = r_p;
                    o_cmd.set = p_ext < i_first_partial;
                    o_cmd.idx = p_ext;
                end else begin
                    n_idx = idx_inc;
                end
            end
            psd_pkg::S_RESP: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_gnt   = r_gnt;
                    n_out_plan  = r_plan;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psd_pkg::S_IDLE;
            r_ptr       <= '0;
            r_none      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_none      <= n_none;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_start    <= n_start;
        r_p        <= n_p;
        r_gnt      <= n_gnt;
        r_plan     <= n_plan;
        r_out_gnt  <= n_out_gnt;
        r_out_plan <= n_out_plan;
    end

    assign o_in_ready  = (r_state == psd_pkg::S_IDLE);
    assign o_probe_idx = r_idx;
    assign o_out_valid = r_out_valid;
    assign o_granted   = r_out_gnt;
    assign o_plan      = r_out_plan;

endmodule
